[hdl/spi_adc_scan_averager_top_assert.svh]
// assertion macros shared by the checker of the scan averager
// no dependencies; taken in by `include where assertions are written
`ifndef SPI_ADC_SCAN_AVERAGER_TOP_ASSERT_SVH
`define SPI_ADC_SCAN_AVERAGER_TOP_ASSERT_SVH

// same-cycle implication, reset masks the check
`define SSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define SSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/ssa_pkg.sv]
// shared types and constants of the spi adc scan averager
// no dependencies; used by the register file, sequencer, output register and top level
`timescale 1ns / 1ps

package ssa_pkg;

	// fixed sizes
	localparam int MAX_CHANNELS = 8;
	localparam int CH_W         = 3;
	localparam int SAMPLE_BITS  = 12;
	localparam int SUM_W        = 15;
	localparam int PHASE_W      = 6;
	localparam int GAP_W        = 20;

	// conversion waveform landmarks, in ticks from the start of a conversion
	localparam logic [PHASE_W-1:0] PH_LAST       = 6'd41;
	localparam logic [PHASE_W-1:0] PH_CMD_LAST   = 6'd16;
	localparam logic [PHASE_W-1:0] PH_NULL_CLK   = 6'd17;
	localparam logic [PHASE_W-1:0] PH_FIRST_READ = 6'd18;
	localparam logic [PHASE_W-1:0] PH_LAST_READ  = 6'd40;
	localparam logic [PHASE_W-1:0] PH_START_END  = 6'd4;
	localparam logic [PHASE_W-1:0] PH_D2_END     = 6'd6;
	localparam logic [PHASE_W-1:0] PH_D1_END     = 6'd8;

	// register map
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_AVERAGE_LOG2  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CONV_GAP      = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_SCAN_GAP      = 2'd3;

	// register reset values
	localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd4;
	localparam logic [1:0]  RST_AVERAGE_LOG2  = 2'd2;
	localparam logic [15:0] RST_CONV_GAP      = 16'd6;
	localparam logic [19:0] RST_SCAN_GAP      = 20'd400000;

	typedef struct packed {
		logic [3:0]  channel_count;
		logic [1:0]  average_log2;
		logic [15:0] conversion_gap_ticks;
		logic [19:0] scan_gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic                   cs_n;
		logic                   sclk;
		logic                   mosi;
		logic                   report_valid;
		logic [CH_W-1:0]        report_channel;
		logic [SAMPLE_BITS-1:0] report_value;
		logic                   report_last;
	} res_t;

endpackage

[hdl/ssa_regs.sv]
// configuration register file behind the apb-style port
// depends on ssa_pkg for the register map and reset values
`timescale 1ns / 1ps

module ssa_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output ssa_pkg::cfg_t      cfg
);

	ssa_pkg::cfg_t                       cfg_q;
	logic [ssa_pkg::REG_IDX_W-1:0]       idx;
	logic                                wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count        <= ssa_pkg::RST_CHANNEL_COUNT;
			cfg_q.average_log2         <= ssa_pkg::RST_AVERAGE_LOG2;
			cfg_q.conversion_gap_ticks <= ssa_pkg::RST_CONV_GAP;
			cfg_q.scan_gap_ticks       <= ssa_pkg::RST_SCAN_GAP;
		end else if (wr_en) begin
			case (idx)
				ssa_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count        <= pwdata[3:0];
				ssa_pkg::REG_AVERAGE_LOG2:  cfg_q.average_log2         <= pwdata[1:0];
				ssa_pkg::REG_CONV_GAP:      cfg_q.conversion_gap_ticks <= pwdata[15:0];
				ssa_pkg::REG_SCAN_GAP:      cfg_q.scan_gap_ticks       <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	// read-back
	always_comb begin
		case (idx)
			ssa_pkg::REG_CHANNEL_COUNT: prdata = {28'd0, cfg_q.channel_count};
			ssa_pkg::REG_AVERAGE_LOG2:  prdata = {30'd0, cfg_q.average_log2};
			ssa_pkg::REG_CONV_GAP:      prdata = {16'd0, cfg_q.conversion_gap_ticks};
			ssa_pkg::REG_SCAN_GAP:      prdata = {12'd0, cfg_q.scan_gap_ticks};
			default:                    prdata = 32'd0;
		endcase
	end

endmodule

[hdl/ssa_seq.sv]
// tick sequencer: conversion waveform, gaps, per-channel sums and reports
// depends on ssa_pkg for the config and result structs and waveform constants
`timescale 1ns / 1ps

module ssa_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          miso,
	input  ssa_pkg::cfg_t cfg,
	output ssa_pkg::res_t res
);

	typedef enum logic [1:0] {
		MODE_CONV = 2'd0,
		MODE_CGAP = 2'd1,
		MODE_SGAP = 2'd2,
		MODE_IGAP = 2'd3
	} mode_t;

	localparam int CW = ssa_pkg::CH_W;
	localparam int PW = ssa_pkg::PHASE_W;
	localparam int GW = ssa_pkg::GAP_W;
	localparam int SW = ssa_pkg::SUM_W;
	localparam int BW = ssa_pkg::SAMPLE_BITS;

	mode_t          mode_q, mode_d;
	logic [PW-1:0]  phase_q, phase_d;
	logic [GW-1:0]  gap_q, gap_d, gap_inc;
	logic [CW-1:0]  ch_q, ch_d, rnd_q, rnd_d;
	logic [BW-1:0]  shift_q, shift_d;
	logic [2:0]     pins_q, pins_d;
	logic [SW-1:0]  sums_q [ssa_pkg::MAX_CHANNELS];
	logic [CW-1:0]  rd_idx;
	logic [SW-1:0]  sum_rd, sum_wdata, sum_shr;
	logic           sum_we, sum_clr, do_adv;
	logic [3:0]     eff_cnt, rounds;
	logic [GW-1:0]  scan_len;
	logic           cs, sc, di;

	// effective channel count and gap lengths
	always_comb begin
		if (cfg.channel_count == 4'd0)
			eff_cnt = 4'd1;
		else if (cfg.channel_count > 4'(ssa_pkg::MAX_CHANNELS))
			eff_cnt = 4'(ssa_pkg::MAX_CHANNELS);
		else
			eff_cnt = cfg.channel_count;
		rounds   = 4'd1 << cfg.average_log2;
		scan_len = (cfg.scan_gap_ticks < {16'd0, eff_cnt}) ? {16'd0, eff_cnt}
			: cfg.scan_gap_ticks;
	end

	// pin waveform decode for the current phase
	always_comb begin
		cs = (phase_q == '0) || (phase_q == ssa_pkg::PH_LAST);
		if (phase_q == '0 || phase_q == ssa_pkg::PH_NULL_CLK)
			sc = 1'b1;
		else if (phase_q <= ssa_pkg::PH_CMD_LAST)
			sc = !phase_q[0];
		else if (phase_q <= ssa_pkg::PH_LAST_READ)
			sc = phase_q[0];
		else
			sc = 1'b0;
		if (phase_q == '0)
			di = 1'b0;
		else if (phase_q <= ssa_pkg::PH_START_END)
			di = 1'b1;
		else if (phase_q <= ssa_pkg::PH_D2_END)
			di = ch_q[2];
		else if (phase_q <= ssa_pkg::PH_D1_END)
			di = ch_q[1];
		else
			di = ch_q[0];
	end

	// single sum read: conversion end or report
	assign rd_idx  = (mode_q == MODE_CONV) ? ch_q : gap_q[CW-1:0];
	assign sum_rd  = sums_q[rd_idx];
	assign sum_shr = sum_rd >> cfg.average_log2;
	assign gap_inc = gap_q + 20'd1;

	// next state and result
	always_comb begin
		mode_d    = mode_q;
		phase_d   = phase_q;
		gap_d     = gap_q;
		ch_d      = ch_q;
		rnd_d     = rnd_q;
		shift_d   = shift_q;
		pins_d    = pins_q;
		sum_we    = 1'b0;
		sum_clr   = 1'b0;
		sum_wdata = sum_rd + {3'd0, shift_q};
		do_adv    = 1'b0;
		res.report_valid   = 1'b0;
		res.report_channel = '0;
		res.report_value   = '0;
		res.report_last    = 1'b0;

		case (mode_q)
			MODE_CONV: begin
				pins_d = {cs, sc, di};
				if (phase_q >= ssa_pkg::PH_FIRST_READ && phase_q <= ssa_pkg::PH_LAST_READ
						&& !phase_q[0])
					shift_d = {shift_q[BW-2:0], miso};
				if (phase_q >= ssa_pkg::PH_LAST) begin
					sum_we  = 1'b1;
					shift_d = '0;
					phase_d = '0;
					gap_d   = '0;
					if (cfg.conversion_gap_ticks == 16'd0)
						do_adv = 1'b1;
					else
						mode_d = MODE_CGAP;
				end else begin
					phase_d = phase_q + 6'd1;
				end
			end
			MODE_CGAP: begin
				gap_d = gap_inc;
				if (gap_inc >= {4'd0, cfg.conversion_gap_ticks})
					do_adv = 1'b1;
			end
			default: begin
				// scan gap, with reports only after a real scan
				if (mode_q == MODE_SGAP && gap_q < {16'd0, eff_cnt}) begin
					res.report_valid   = 1'b1;
					res.report_channel = gap_q[CW-1:0];
					res.report_value   = (|sum_shr[SW-1:BW]) ? {BW{1'b1}} : sum_shr[BW-1:0];
					res.report_last    = (gap_inc == {16'd0, eff_cnt});
				end
				gap_d = gap_inc;
				if (gap_inc >= scan_len) begin
					gap_d   = '0;
					sum_clr = 1'b1;
					ch_d    = '0;
					rnd_d   = '0;
					phase_d = '0;
					shift_d = '0;
					mode_d  = MODE_CONV;
				end
			end
		endcase

		// step to the next channel, round or the scan gap
		if (do_adv) begin
			if (({1'b0, ch_q} + 4'd1) < eff_cnt) begin
				ch_d    = ch_q + 3'd1;
				phase_d = '0;
				mode_d  = MODE_CONV;
			end else begin
				ch_d = '0;
				if (({1'b0, rnd_q} + 4'd1) < rounds) begin
					rnd_d   = rnd_q + 3'd1;
					phase_d = '0;
					mode_d  = MODE_CONV;
				end else begin
					rnd_d  = '0;
					gap_d  = '0;
					mode_d = MODE_SGAP;
				end
			end
		end

		res.cs_n = pins_d[2];
		res.sclk = pins_d[1];
		res.mosi = pins_d[0];
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IGAP;
			phase_q <= '0;
			gap_q   <= '0;
			ch_q    <= '0;
			rnd_q   <= '0;
			shift_q <= '0;
			pins_q  <= 3'b110;
		end else if (step) begin
			mode_q  <= mode_d;
			phase_q <= phase_d;
			gap_q   <= gap_d;
			ch_q    <= ch_d;
			rnd_q   <= rnd_d;
			shift_q <= shift_d;
			pins_q  <= pins_d;
		end
	end

	// per-channel sums, cleared at scan start
	always_ff @(posedge clk) begin
		if (step) begin
			if (sum_clr) begin
				for (int i = 0; i < ssa_pkg::MAX_CHANNELS; i++)
					sums_q[i] <= '0;
			end else if (sum_we) begin
				sums_q[ch_q] <= sum_wdata;
			end
		end
	end

endmodule

[hdl/ssa_out.sv]
// result register between the sequencer and the output channel
// depends on ssa_pkg for the result struct
`timescale 1ns / 1ps

module ssa_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  ssa_pkg::res_t res,
	input  logic          result_ready,
	output logic          result_valid,
	output logic          space,
	output ssa_pkg::res_t res_q
);

	logic valid_q;

	assign result_valid = valid_q;
	assign space        = !valid_q || result_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (result_ready)
			valid_q <= 1'b0;
	end

	// payload
	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

endmodule

[hdl/spi_adc_scan_averager_top.sv]
// latency: the result for a tick is shown the cycle after the tick is accepted
// throughput: one tick per cycle while results are taken; the result register frees as it is taken
// the sequencer state updates in one pass from the accepted tick
// reset: asynchronous, registers to defaults, sequencer in the initial scan gap
// top level of the spi adc scan averager; depends on ssa_pkg, ssa_regs,
// ssa_seq and ssa_out
`timescale 1ns / 1ps

module spi_adc_scan_averager_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        miso,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        cs_n,
	output logic        sclk,
	output logic        mosi,
	output logic        report_valid,
	output logic [2:0]  report_channel,
	output logic [11:0] report_value,
	output logic        report_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	ssa_pkg::cfg_t cfg;
	ssa_pkg::res_t res, res_q;
	logic          step, space;

	assign item_ready = space;
	assign step       = item_valid && space;

	// configuration registers
	ssa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// tick sequencer
	ssa_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.miso   (miso),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	ssa_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step),
		.res          (res),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.space        (space),
		.res_q        (res_q)
	);

	assign cs_n           = res_q.cs_n;
	assign sclk           = res_q.sclk;
	assign mosi           = res_q.mosi;
	assign report_valid   = res_q.report_valid;
	assign report_channel = res_q.report_channel;
	assign report_value   = res_q.report_value;
	assign report_last    = res_q.report_last;

endmodule

[hdl/ssa_checker.sv]
// port-level checks of the scan averager, bound to the top level
// depends on spi_adc_scan_averager_top_assert.svh for the assertion macros
`timescale 1ns / 1ps

`include "spi_adc_scan_averager_top_assert.svh"

module ssa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic        cs_n,
	input logic        sclk,
	input logic        report_valid,
	input logic [2:0]  report_channel,
	input logic [11:0] report_value,
	input logic        report_last
);

	// a stalled result holds
	`SSA_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(report_value) && $stable(report_channel) && $stable(cs_n), "stalled result changed")

	// requests are only refused while a result waits
	`SSA_ASSERT_NOW(a_ready, !item_ready, result_valid && !result_ready, "request refused with free output")

	// reports come only in a gap, pins parked after a conversion
	`SSA_ASSERT_NOW(a_rep_pins, result_valid && report_valid, cs_n && !sclk, "report outside a gap")

	// fields without a report are zero, last implies a report
	`SSA_ASSERT_NOW(a_rep_zero, result_valid && !report_valid, report_channel == 3'd0 && report_value == 12'd0 && !report_last, "report fields set without report")

endmodule

bind spi_adc_scan_averager_top ssa_checker u_checker (.*);
